[rtl/hvs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hvs_pkg
// Shared widths, register indexes and CORDIC constants of the heading shaper.
// ----------------------------------------------------------------------------
package hvs_pkg;

  localparam int unsigned VelW   = 16;
  localparam int unsigned AngW   = 16;
  localparam int unsigned CfgW   = 15;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CordicSteps = 18;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ALPHA    = 3'd0,
    CFG_ANG_GAIN = 3'd1,
    CFG_MAX_RATE = 3'd2,
    CFG_LIN_GAIN = 3'd3,
    CFG_MAX_LIN  = 3'd4
  } cfg_idx_e;

  localparam logic signed [31:0] Pi29   = 32'sd1686629713;
  localparam logic signed [31:0] InvK30 = 32'sd652032874;

  function automatic logic signed [31:0] atan_entry(input logic [4:0] idx);
    logic signed [31:0] v;
    case (idx)
      5'd0:    v = 32'sd536870912;
      5'd1:    v = 32'sd316933406;
      5'd2:    v = 32'sd167458907;
      5'd3:    v = 32'sd85004756;
      5'd4:    v = 32'sd42667331;
      5'd5:    v = 32'sd21354465;
      5'd6:    v = 32'sd10680862;
      5'd7:    v = 32'sd5340245;
      5'd8:    v = 32'sd2670163;
      5'd9:    v = 32'sd1335087;
      5'd10:   v = 32'sd667544;
      5'd11:   v = 32'sd333772;
      5'd12:   v = 32'sd166886;
      5'd13:   v = 32'sd83443;
      5'd14:   v = 32'sd41722;
      5'd15:   v = 32'sd20861;
      5'd16:   v = 32'sd10430;
      5'd17:   v = 32'sd5215;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[rtl/hvs_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hvs_if
// Valid/ready channels for the heading shaper: one input tick, one command.
// ----------------------------------------------------------------------------
interface hvs_in_if import hvs_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [VelW-1:0] vel_row;
  logic signed [VelW-1:0] vel_col;
  logic signed [AngW-1:0] robot_yaw;
  logic                   mppi_valid;
  logic                   new_plan;

  modport source (output valid, vel_row, vel_col, robot_yaw, mppi_valid, new_plan,
                  input ready);
  modport sink   (input valid, vel_row, vel_col, robot_yaw, mppi_valid, new_plan,
                  output ready);
endinterface

interface hvs_out_if import hvs_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [VelW-1:0] angular_rate;
  logic signed [VelW-1:0] linear_speed;

  modport source (output valid, angular_rate, linear_speed, input ready);
  modport sink   (input valid, angular_rate, linear_speed, output ready);
endinterface
`default_nettype wire

[rtl/heading_velocity_shaper.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// heading_velocity_shaper
// Proportional heading controller: filtered planner velocity to (wz, v).
// ----------------------------------------------------------------------------
// Sequencing: a stop tick (mppi_valid low) goes through S_STOP to the command
// register; a moving tick takes two 18-step passes of the shared CORDIC stage
// (one when the filtered velocity is zero) and seven shared multiplier passes.
// Throughput: one tick at a time; a new tick is taken only once the command
// of the last one is loaded into the output register.
// Reset: asynchronous active low; clears the sequencer, the filter and heading
// state, and loads the register defaults. No clearing pass is needed.
// ----------------------------------------------------------------------------
module heading_velocity_shaper import hvs_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_data_i,
  hvs_in_if.sink                  in_i,
  hvs_out_if.source               out_o
);

  // One-hot sequencer.
  typedef enum logic [16:0] {
    S_IDLE   = 17'h00001,
    S_STOP   = 17'h00002,
    S_FILT   = 17'h00004,
    S_VINIT  = 17'h00008,
    S_VEC    = 17'h00010,
    S_SMUL   = 17'h00020,
    S_SDONE  = 17'h00040,
    S_RMUL1  = 17'h00080,
    S_RMUL2  = 17'h00100,
    S_RINIT  = 17'h00200,
    S_ROT    = 17'h00400,
    S_PMUL1  = 17'h00800,
    S_PMUL2  = 17'h01000,
    S_PCLAMP = 17'h02000,
    S_PMUL3  = 17'h04000,
    S_PMUL4  = 17'h08000,
    S_PDONE  = 17'h10000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [8:0]  alpha_q;
  logic [11:0] ang_gain_q;
  logic [14:0] max_rate_q;
  logic [11:0] lin_gain_q;
  logic [14:0] max_lin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q    <= 9'd128;
      ang_gain_q <= 12'd512;
      max_rate_q <= 15'd4096;
      lin_gain_q <= 12'd256;
      max_lin_q  <= 15'd2048;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ALPHA:    alpha_q    <= cfg_data_i[8:0];
        CFG_ANG_GAIN: ang_gain_q <= cfg_data_i[11:0];
        CFG_MAX_RATE: max_rate_q <= cfg_data_i;
        CFG_LIN_GAIN: lin_gain_q <= cfg_data_i[11:0];
        CFG_MAX_LIN:  max_lin_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Latched tick fields.
  logic signed [15:0] vr_q, vc_q, yaw_q;

  // Controller state.
  logic signed [15:0] last_row_q, last_col_q, last_head_q;
  logic               known_q;

  // Working registers.
  logic signed [33:0] x_q, y_q;
  logic signed [31:0] z_q;
  logic [4:0]         iter_q;
  logic signed [15:0] desired_q, err_q, rate_q;
  logic signed [17:0] p_q;
  logic signed [65:0] prod_q;

  // Output register.
  logic               out_valid_q;
  logic signed [15:0] out_rate_q, out_lin_q;

  logic in_xfer, out_free, out_load;
  assign in_i.ready = (state_q == S_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  // Shared CORDIC micro-rotation.
  logic               vec_mode, up;
  logic signed [33:0] xs, ys, x_step, y_step;
  logic signed [31:0] atan_v, z_step;
  logic               last_iter;

  assign vec_mode  = (state_q == S_VEC);
  assign xs        = x_q >>> iter_q;
  assign ys        = y_q >>> iter_q;
  assign atan_v    = atan_entry(iter_q);
  assign up        = vec_mode ? (y_q > 34'sd0) : (z_q < 32'sd0);
  assign x_step    = up ? (x_q + ys) : (x_q - ys);
  assign y_step    = up ? (y_q - xs) : (y_q + xs);
  assign z_step    = up ? (z_q + atan_v) : (z_q - atan_v);
  assign last_iter = (iter_q == 5'(CordicSteps - 1));

  // Shared multiplier: operands by state, product registered.
  logic signed [33:0] mul_a;
  logic signed [31:0] mul_b;
  logic               mul_en;
  logic signed [15:0] delta;
  logic [16:0]        aerr;
  logic [16:0]        ts_raw;
  logic [14:0]        ts;

  assign delta  = desired_q - last_head_q;
  assign aerr   = err_q[15] ? (17'd0 - {err_q[15], err_q}) : {1'b0, err_q};
  assign ts_raw = 17'd16384 - aerr;
  // Floor the turn scale at 0.2 in Q.14; a large error wraps ts_raw negative.
  assign ts     = (ts_raw[16] || ts_raw < 17'd3277) ? 15'd3277 : ts_raw[14:0];

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    unique case (state_q)
      S_SMUL: begin
        mul_a = {25'd0, alpha_q};
        mul_b = 32'(delta);
      end
      S_RMUL1: begin
        mul_a = {22'd0, ang_gain_q};
        mul_b = 32'(err_q);
      end
      S_RMUL2: begin
        mul_a = prod_q[33:0];
        mul_b = Pi29;
      end
      S_PMUL1: begin
        mul_a = x_q;
        mul_b = InvK30;
      end
      S_PMUL2: begin
        mul_a = prod_q[63:30];
        mul_b = {20'd0, lin_gain_q};
      end
      S_PMUL3: begin
        mul_a = 34'(p_q);
        mul_b = {17'd0, max_lin_q};
      end
      S_PMUL4: begin
        mul_a = prod_q[33:0];
        mul_b = {17'd0, ts};
      end
      default: mul_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) prod_q <= mul_a * mul_b;
  end

  // Filter, smoothing, clamps.
  logic signed [18:0] f_row, f_col;
  assign f_row = (19'(last_row_q) + 19'(vr_q) + (19'(vr_q) <<< 1) + 19'sd2) >>> 2;
  assign f_col = (19'(last_col_q) + 19'(vc_q) + (19'(vc_q) <<< 1) + 19'sd2) >>> 2;

  logic signed [25:0] sm_sum;
  logic signed [15:0] smooth;
  assign sm_sum = prod_q[25:0] + 26'sd128;
  assign smooth = known_q ? (last_head_q + sm_sum[23:8]) : desired_q;

  logic signed [65:0] rate_sum;
  logic signed [25:0] rate_full, rate_lim;
  assign rate_sum  = prod_q + (66'sd1 <<< 39);
  assign rate_full = rate_sum[65:40];
  assign rate_lim  = {11'd0, max_rate_q};

  logic signed [65:0] p_sum;
  logic signed [47:0] p_full;
  assign p_sum  = prod_q + (66'sd1 <<< 17);
  assign p_full = p_sum[65:18];

  logic signed [65:0] lin_sum;
  assign lin_sum = prod_q + (66'sd1 <<< 29);

  logic signed [31:0] zrot, yaw_ext;
  assign yaw_ext = {yaw_q, 16'h0000};
  assign zrot    = 32'sd0 - yaw_ext;

  logic signed [31:0] z_fin;
  assign z_fin = z_step + 32'sd32768;

  assign out_load = ((state_q == S_PDONE) || (state_q == S_STOP)) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_xfer) state_d = in_i.mppi_valid ? S_FILT : S_STOP;
      S_STOP:   if (out_free) state_d = S_IDLE;
      S_FILT:   state_d = S_VINIT;
      S_VINIT:  state_d = (last_row_q == 16'sd0 && last_col_q == 16'sd0) ? S_SMUL : S_VEC;
      S_VEC:    if (last_iter) state_d = S_SMUL;
      S_SMUL:   state_d = S_SDONE;
      S_SDONE:  state_d = S_RMUL1;
      S_RMUL1:  state_d = S_RMUL2;
      S_RMUL2:  state_d = S_RINIT;
      S_RINIT:  state_d = S_ROT;
      S_ROT:    if (last_iter) state_d = S_PMUL1;
      S_PMUL1:  state_d = S_PMUL2;
      S_PMUL2:  state_d = S_PCLAMP;
      S_PCLAMP: state_d = S_PMUL3;
      S_PMUL3:  state_d = S_PMUL4;
      S_PMUL4:  state_d = S_PDONE;
      S_PDONE:  if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      last_row_q  <= '0;
      last_col_q  <= '0;
      last_head_q <= '0;
      known_q     <= 1'b0;
      out_valid_q <= 1'b0;
      iter_q      <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;

      unique case (state_q)
        S_IDLE: begin
          // Clear the smoothing state on a new plan, even on a stop tick.
          if (in_xfer && in_i.new_plan) begin
            last_row_q <= '0;
            last_col_q <= '0;
            known_q    <= 1'b0;
          end
        end
        S_FILT: begin
          last_row_q <= f_row[15:0];
          last_col_q <= f_col[15:0];
        end
        S_VINIT, S_RINIT: iter_q <= '0;
        S_VEC, S_ROT: iter_q <= iter_q + 5'd1;
        S_SDONE: begin
          last_head_q <= smooth;
          known_q     <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      vr_q  <= in_i.vel_row;
      vc_q  <= in_i.vel_col;
      yaw_q <= in_i.robot_yaw;
    end
    case (state_q)
      S_VINIT: begin
        desired_q <= yaw_q;
        // Fold the left half plane over so the vectoring pass converges.
        if (last_col_q < 16'sd0) begin
          x_q <= 34'sd0 - (34'(last_col_q) <<< 14);
          y_q <= 34'sd0 - (34'(last_row_q) <<< 14);
          z_q <= 32'h8000_0000;
        end else begin
          x_q <= 34'(last_col_q) <<< 14;
          y_q <= 34'(last_row_q) <<< 14;
          z_q <= '0;
        end
      end
      S_VEC, S_ROT: begin
        x_q <= x_step;
        y_q <= y_step;
        z_q <= z_step;
        if (vec_mode && last_iter) desired_q <= z_fin[31:16];
      end
      S_SDONE: err_q <= smooth - yaw_q;
      S_RINIT: begin
        if (rate_full > rate_lim) rate_q <= {1'b0, max_rate_q};
        else if (rate_full < -rate_lim) rate_q <= 16'sd0 - {1'b0, max_rate_q};
        else rate_q <= rate_full[15:0];
        // Rotate by a half turn first when the angle lies outside +-pi/2.
        if (zrot > 32'sd1073741824 || zrot < -32'sd1073741824) begin
          x_q <= 34'sd0 - (34'(last_col_q) <<< 14);
          y_q <= 34'sd0 - (34'(last_row_q) <<< 14);
          z_q <= zrot + 32'h8000_0000;
        end else begin
          x_q <= 34'(last_col_q) <<< 14;
          y_q <= 34'(last_row_q) <<< 14;
          z_q <= zrot;
        end
      end
      S_PCLAMP: begin
        if (p_full > 48'sd65536) p_q <= 18'sd65536;
        else if (p_full < -48'sd65536) p_q <= -18'sd65536;
        else p_q <= p_full[17:0];
      end
      default: ;
    endcase
    if (out_load) begin
      if (state_q == S_STOP) begin
        out_rate_q <= '0;
        out_lin_q  <= '0;
      end else begin
        out_rate_q <= rate_q;
        out_lin_q  <= lin_sum[45:30];
      end
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.angular_rate = out_rate_q;
  assign out_o.linear_speed = out_lin_q;

endmodule
`default_nettype wire

[tb/heading_velocity_shaper_tb.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// heading_velocity_shaper_tb
// Self-checking bench for the heading shaper. Ticks go in on the input
// channel with random gaps. Commands come out against random back-pressure
// and are checked field by field against an in-bench predictor of the filter,
// the CORDIC heading, the smoothing and the gain stages. Several register
// settings are visited, the extremes among them.
// ----------------------------------------------------------------------------
module heading_velocity_shaper_tb;
  import hvs_pkg::*;

  typedef struct {
    logic signed [15:0] vel_row;
    logic signed [15:0] vel_col;
    logic signed [15:0] yaw;
    logic               moving;
    logic               fresh;
  } tick_t;

  typedef struct {
    logic signed [15:0] rate;
    logic signed [15:0] speed;
  } cmd_t;

  // Predictor plus the queue of commands it has worked out but not yet seen.
  class cmd_scoreboard;
    longint arctan_q31[18] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                               21354465, 10680862, 5340245, 2670163, 1335087, 667544,
                               333772, 166886, 83443, 41722, 20861, 10430, 5215};
    logic [8:0]  alpha = 9'd128;
    logic [11:0] ang_gain = 12'd512;
    logic [14:0] rate_lim = 15'd4096;
    logic [11:0] lin_gain = 12'd256;
    logic [14:0] speed_lim = 15'd2048;
    longint filt_row = 0, filt_col = 0, heading = 0;
    bit     heading_valid = 0;
    cmd_t   cmd_q[$];
    int     errors = 0;

    function automatic longint wrap16(longint v);
      logic signed [15:0] t;
      t = v[15:0];
      return t;
    endfunction

    function automatic longint wrap32(longint v);
      logic signed [31:0] t;
      t = v[31:0];
      return t;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] d);
      case (idx)
        CFG_ALPHA:    alpha = d[8:0];
        CFG_ANG_GAIN: ang_gain = d[11:0];
        CFG_MAX_RATE: rate_lim = d[14:0];
        CFG_LIN_GAIN: lin_gain = d[11:0];
        CFG_MAX_LIN:  speed_lim = d[14:0];
        default: ;
      endcase
    endfunction

    // Vectoring CORDIC: binary angle of (x, y).
    function automatic longint heading_of(longint xi, longint yi);
      longint x, y, z, xs, ys;
      x = xi * 16384;
      y = yi * 16384;
      z = 0;
      if (x < 0) begin
        x = -x;
        y = -y;
        z = 64'sd2147483648;
      end
      for (int i = 0; i < 18; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x = x + ys; y = y - xs; z += arctan_q31[i];
        end else begin
          x = x - ys; y = y + xs; z -= arctan_q31[i];
        end
      end
      z = wrap32(z);
      return wrap16((z + 32768) >>> 16);
    endfunction

    // Rotation CORDIC: component of (x, y) along the yaw, gain corrected.
    function automatic longint forward_of(longint xi, longint yi, longint a);
      longint x, y, z, xs, ys;
      x = xi * 16384;
      y = yi * 16384;
      z = wrap32(-a * 65536);
      if (z > 64'sd1073741824 || z < -64'sd1073741824) begin
        x = -x;
        y = -y;
        z = wrap32(z + 64'sd2147483648);
      end
      for (int i = 0; i < 18; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x = x - ys; y = y + xs; z -= arctan_q31[i];
        end else begin
          x = x + ys; y = y - xs; z += arctan_q31[i];
        end
      end
      return (x * 64'sd652032874) >>> 30;
    endfunction

    function void note_tick(tick_t t);
      longint desired, smooth, err, aerr, rate, fwd, p, ts, lin, yaw;
      cmd_t c;
      yaw = t.yaw;
      if (t.fresh) begin
        filt_row = 0;
        filt_col = 0;
        heading_valid = 0;
      end
      if (!t.moving) begin
        c.rate = '0;
        c.speed = '0;
        cmd_q = {cmd_q, c};
        return;
      end
      filt_row = (filt_row + 3 * longint'(t.vel_row) + 2) >>> 2;
      filt_col = (filt_col + 3 * longint'(t.vel_col) + 2) >>> 2;
      desired = (filt_row == 0 && filt_col == 0) ? yaw : heading_of(filt_col, filt_row);
      if (!heading_valid) begin
        smooth = desired;
        heading_valid = 1;
      end else begin
        smooth = wrap16(heading +
                        ((longint'(alpha) * wrap16(desired - heading) + 128) >>> 8));
      end
      heading = smooth;
      err = wrap16(smooth - yaw);
      aerr = err < 0 ? -err : err;
      rate = (longint'(ang_gain) * err * 64'sd1686629713 + (64'sd1 << 39)) >>> 40;
      if (rate > longint'(rate_lim)) rate = rate_lim;
      if (rate < -longint'(rate_lim)) rate = -longint'(rate_lim);
      fwd = forward_of(filt_col, filt_row, yaw);
      p = (fwd * longint'(lin_gain) + (64'sd1 << 17)) >>> 18;
      if (p > 65536) p = 65536;
      if (p < -65536) p = -65536;
      ts = 16384 - aerr;
      if (ts < 3277) ts = 3277;
      lin = (p * longint'(speed_lim) * ts + (64'sd1 << 29)) >>> 30;
      c.rate = rate[15:0];
      c.speed = lin[15:0];
      cmd_q = {cmd_q, c};
    endfunction

    function void check_cmd(logic signed [15:0] rate, logic signed [15:0] speed);
      cmd_t c;
      if (cmd_q.size() == 0) begin
        $error("unexpected command: angular_rate %0d linear_speed %0d", rate, speed);
        errors++;
        return;
      end
      c = cmd_q.pop_front();
      if (rate !== c.rate) begin
        $error("angular_rate: expected %0d, got %0d", c.rate, rate);
        errors++;
      end
      if (speed !== c.speed) begin
        $error("linear_speed: expected %0d, got %0d", c.speed, speed);
        errors++;
      end
    endfunction
  endclass

  localparam int TailCycles = 80;
  localparam int StallLimit = 4000;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0] cfg_data_i;

  hvs_in_if  in_if ();
  hvs_out_if out_if ();

  heading_velocity_shaper u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  cmd_scoreboard sb = new();
  bit  gaps_on = 1'b1;     // cleared for the last phase: full rate on both sides
  int  cmd_seen = 0;
  int  quiet_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hold every block input at a known value from time zero.
  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.vel_row = '0;
    in_if.vel_col = '0;
    in_if.robot_yaw = '0;
    in_if.mppi_valid = 1'b0;
    in_if.new_plan = 1'b0;
    out_if.ready = 1'b0;
  end

  // Command sink: check each transfer, then pick ready for the next cycle.
  // Once, early on, hold off for a long stretch so the block backs up into
  // its input channel while the sender keeps offering ticks.
  initial begin
    int stall_left;
    int hold_left;
    bit held;
    stall_left = 0;
    hold_left = 0;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        sb.check_cmd(out_if.angular_rate, out_if.linear_speed);
        cmd_seen++;
      end
      if (!held && cmd_seen == 150) begin
        held = 1'b1;
        hold_left = 500;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if nothing transfers for too long.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("** heading_velocity_shaper: FAILED **");
        $finish;
      end
    end
  end

  // Offer one tick, with an optional random gap first; note it on transfer.
  task automatic send_tick(tick_t t);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.vel_row <= t.vel_row;
    in_if.vel_col <= t.vel_col;
    in_if.robot_yaw <= t.yaw;
    in_if.mppi_valid <= t.moving;
    in_if.new_plan <= t.fresh;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_tick(t);
  endtask

  task automatic send_fields(int vr, int vc, int yaw, bit mv, bit np);
    tick_t t;
    t.vel_row = vr[15:0];
    t.vel_col = vc[15:0];
    t.yaw = yaw[15:0];
    t.moving = mv;
    t.fresh = np;
    send_tick(t);
  endtask

  // Drain all commands, let a stop tick still in flight settle, then write
  // all registers plus one unused index, which must be ignored.
  task automatic load_regs(int a, int kg, int wz, int kl, int vm);
    int vals[5];
    vals = '{a, kg, wz, kl, vm};
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.cmd_q.size() != 0);
    repeat (TailCycles) @(posedge clk_i);
    for (int i = 0; i < 5; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= cfg_idx_e'(i);
      cfg_data_i <= vals[i][CfgW-1:0];
      sb.set_reg(cfg_idx_e'(i), vals[i][CfgW-1:0]);
      @(posedge clk_i);
    end
    cfg_idx_i <= CfgIdxW'($urandom_range(5, 7));
    cfg_data_i <= CfgW'($urandom);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Random traffic: mostly plan-shaped runs (a fresh start, then a velocity
  // that wanders slowly and a yaw that drifts at random), the rest noise and stops.
  task automatic random_ticks(int count);
    int vr, vc, yaw, left;
    vr = 0;
    vc = 0;
    yaw = 0;
    left = 0;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 4) == 0) begin
        send_fields($urandom, $urandom, $urandom, $urandom_range(0, 1), $urandom_range(0, 1));
      end else begin
        if (left == 0) begin
          left = $urandom_range(4, 30);
          vr = $signed(16'($urandom)) >>> $urandom_range(0, 4);
          vc = $signed(16'($urandom)) >>> $urandom_range(0, 4);
          yaw = $urandom;
          send_fields(vr, vc, yaw, 1'b1, 1'b1);
        end else begin
          left--;
          vr = vr + $urandom_range(0, 800) - 400;
          vc = vc + $urandom_range(0, 800) - 400;
          yaw = yaw + $urandom_range(0, 4000) - 2000;
          if ($urandom_range(0, 15) == 0) begin
            vr = 0;
            vc = 0;
          end
          send_fields(vr, vc, yaw, $urandom_range(0, 11) != 0, 1'b0);
        end
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed ticks at reset settings.
    send_fields(0, 0, 0, 1'b1, 1'b0);                // zero velocity: heading is yaw
    send_fields(0, 0, -32768, 1'b1, 1'b0);
    send_fields(32767, 32767, 32767, 1'b1, 1'b0);
    send_fields(-32768, -32768, -32768, 1'b1, 1'b0);
    send_fields(-32768, 32767, 12345, 1'b1, 1'b0);
    send_fields(32767, -32768, -12345, 1'b1, 1'b0);
    send_fields(1000, 2000, 3000, 1'b0, 1'b0);       // stop: zeros, state kept
    send_fields(1000, 2000, 3000, 1'b1, 1'b0);
    send_fields(555, 777, 999, 1'b0, 1'b1);          // stop still clears
    send_fields(0, 32767, -32768, 1'b1, 1'b0);       // heading error of pi
    send_fields(0, 32767, -32768, 1'b1, 1'b1);
    send_fields(0, -4096, 0, 1'b1, 1'b1);            // heading of pi, backing up
    send_fields(-4096, 0, 16384, 1'b1, 1'b0);
    send_fields(4096, 0, -16384, 1'b1, 1'b0);
    send_fields(1, 1, 1, 1'b1, 1'b1);
    send_fields(0, 0, 7, 1'b1, 1'b1);
    random_ticks(140);

    load_regs(256, 4095, 32767, 4095, 32767);
    send_fields(0, 32767, -32768, 1'b1, 1'b1);
    send_fields(32767, 0, 0, 1'b1, 1'b0);
    send_fields(-32768, -32768, 32767, 1'b1, 1'b0);
    random_ticks(150);

    load_regs(0, 0, 0, 0, 0);
    random_ticks(120);

    load_regs(511, 4095, 32767, 4095, 32767);        // alpha overshoot
    random_ticks(150);

    load_regs($urandom_range(0, 511), $urandom_range(0, 4095), $urandom_range(0, 32767),
              $urandom_range(0, 4095), $urandom_range(0, 32767));
    random_ticks(150);

    load_regs(64, 1024, 8192, 512, 4096);
    gaps_on = 1'b0;
    random_ticks(170);

    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.cmd_q.size() != 0);
    repeat (TailCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.cmd_q.size() == 0) begin
      $display("** heading_velocity_shaper: PASSED **");
    end else begin
      $display("** heading_velocity_shaper: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire

[heading_velocity_shaper.f]
rtl/hvs_pkg.sv
rtl/hvs_if.sv
rtl/heading_velocity_shaper.sv
tb/heading_velocity_shaper_tb.sv
